// File: src/elu_activation_top_defines.svh
// Assertion macros for the ELU activation block.
`ifndef ELU_ACTIVATION_TOP_DEFINES_SVH
`define ELU_ACTIVATION_TOP_DEFINES_SVH

// Implication that holds in the same cycle.
`define ELU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent ends.
`define ELU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/elu_pkg.sv
`default_nettype none

package elu_pkg;

  localparam int unsigned EXP_TABLE_ENTRIES = 64;

  localparam int IdxW   = $clog2(EXP_TABLE_ENTRIES);
  localparam int RomAw  = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int PosW   = 16 + IdxW;
  localparam int NumStages = 6;

  localparam logic [15:0] AlphaReset = 16'd4096;
  localparam logic [16:0] Log2eQ16   = 17'd94548;
  localparam logic [63:0] Ln2Q32     = 64'd2977044472;
  localparam logic [16:0] OneQ16     = 17'h10000;

  typedef logic [16:0] rom_t [EXP_TABLE_ENTRIES + 1];

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  // 2^(-k/N) in Q16 from an exp series of (N-k)*ln2/N in Q32, halved.
  function automatic logic [16:0] rom_entry(int unsigned k);
    logic [63:0] b;
    logic [63:0] term;
    logic [63:0] sum;
    b = (64'(EXP_TABLE_ENTRIES - k) * Ln2Q32 + 64'(EXP_TABLE_ENTRIES / 2))
        / EXP_TABLE_ENTRIES;
    term = 64'd1 << 32;
    sum  = term;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * b) >> 32) / 64'(i);
      sum  = sum + term;
    end
    return 17'((sum + (64'd1 << 16)) >> 17);
  endfunction

  function automatic rom_t exp_rom_init();
    rom_t r;
    for (int unsigned k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      r[k] = rom_entry(k);
    end
    return r;
  endfunction

  localparam rom_t ExpRom = exp_rom_init();

endpackage

`default_nettype wire

// File: src/elu_x_if.sv
`default_nettype none

interface elu_x_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_in;

  modport source (output valid, output x_in, input ready);
  modport sink   (input valid, input x_in, output ready);
endinterface

`default_nettype wire

// File: src/elu_y_if.sv
`default_nettype none

interface elu_y_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] y_out;

  modport source (output valid, output y_out, input ready);
  modport sink   (input valid, input y_out, output ready);
endinterface

`default_nettype wire

// File: src/elu_pipe_ctl.sv
`default_nettype none

module elu_pipe_ctl
  import elu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] en;

  // a stage loads when it is empty or the stage after it moves
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.en  = en;
  assign ctl_o.vld = vld_q;

endmodule

`default_nettype wire

// File: src/elu_activation_top.sv
// ELU activation, y = max(x,0) + alpha*(exp(min(x,0)) - 1), on signed Q8.8
// items, alpha an unsigned Q4.12 register (reset 1.0). A six-stage pipeline
// takes one item per clock when not stalled and gives its result from the
// last stage register; stages are the log2(e) multiply, table index split,
// table read and slope multiply, interpolation with the power-of-two shift,
// the alpha multiply, and rounding into the output register. A stalled
// output only holds the stages behind it that are full, so empty stages
// keep taking items. Write alpha only while no item is in flight.
`default_nettype none

module elu_activation_top
  import elu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  alpha_gain_we_i,
  input  wire logic  [15:0] alpha_gain_i,
  elu_x_if.sink      x_chan_i,
  elu_y_if.source    y_chan_o
);

  pipe_ctl_t ctl;

  elu_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (x_chan_i.valid),
    .out_ready_i (y_chan_o.ready),
    .ctl_o       (ctl)
  );

  assign x_chan_i.ready = ctl.en[0];

  logic [15:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
    end else if (alpha_gain_we_i) begin
      alpha_q <= alpha_gain_i;
    end
  end

  // stage 1: |x| * log2(e)
  logic [15:0] x_raw;
  logic [15:0] mag_in;
  logic [15:0] s1_x_q;
  logic        s1_neg_q;
  logic [32:0] s1_prod_q;

  assign x_raw  = x_chan_i.x_in;
  assign mag_in = 16'(OneQ16 - 17'(x_raw));

  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      s1_x_q    <= x_raw;
      s1_neg_q  <= x_raw[15];
      s1_prod_q <= 33'(mag_in) * 33'(Log2eQ16);
    end
  end

  // stage 2: split into shift, table index and remainder
  logic [23:0]     t2;
  logic [15:0]     f2;
  logic [PosW-1:0] pos2;
  logic [15:0]     s2_x_q;
  logic            s2_neg_q;
  logic [7:0]      s2_n_q;
  logic [IdxW-1:0] s2_idx_q;
  logic [15:0]     s2_rem_q;

  assign t2   = 24'((s1_prod_q + 33'd128) >> 8);
  assign f2   = t2[15:0];
  assign pos2 = PosW'(f2) * PosW'(EXP_TABLE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (ctl.en[1]) begin
      s2_x_q   <= s1_x_q;
      s2_neg_q <= s1_neg_q;
      s2_n_q   <= t2[23:16];
      s2_idx_q <= pos2[PosW-1:16];
      s2_rem_q <= pos2[15:0];
    end
  end

  // stage 3: table read and slope times remainder
  logic [RomAw-1:0] hi_addr, lo_addr;
  logic [16:0]      hi3, lo3;
  logic [15:0]      s3_x_q;
  logic             s3_neg_q;
  logic [7:0]       s3_n_q;
  logic [16:0]      s3_hi_q;
  logic [32:0]      s3_prod_q;

  assign hi_addr = RomAw'(s2_idx_q);
  assign lo_addr = hi_addr + RomAw'(1);
  assign hi3     = ExpRom[hi_addr];
  assign lo3     = ExpRom[lo_addr];

  always_ff @(posedge clk_i) begin
    if (ctl.en[2]) begin
      s3_x_q    <= s2_x_q;
      s3_neg_q  <= s2_neg_q;
      s3_n_q    <= s2_n_q;
      s3_hi_q   <= hi3;
      s3_prod_q <= 33'(hi3 - lo3) * 33'(s2_rem_q);
    end
  end

  // stage 4: interpolate, scale by 2^-n with rounding, form 1 - exp
  logic [17:0] corr4, v4, rnd4, e4;
  logic [16:0] d4;
  logic [15:0] s4_x_q;
  logic        s4_neg_q;
  logic [16:0] s4_d_q;

  always_comb begin
    corr4 = 18'((34'(s3_prod_q) + 34'd32768) >> 16);
    v4    = 18'(s3_hi_q) - corr4;
    rnd4  = (s3_n_q == 8'd0) ? 18'd0 : (18'd1 << (s3_n_q[4:0] - 5'd1));
    if (s3_n_q >= 8'd24) begin
      e4 = '0;
    end else begin
      e4 = (v4 + rnd4) >> s3_n_q[4:0];
    end
    d4 = (e4 >= 18'(OneQ16)) ? 17'd0 : 17'(18'(OneQ16) - e4);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[3]) begin
      s4_x_q   <= s3_x_q;
      s4_neg_q <= s3_neg_q;
      s4_d_q   <= d4;
    end
  end

  // stage 5: alpha multiply
  logic [15:0] s5_x_q;
  logic        s5_neg_q;
  logic [32:0] s5_prod_q;

  always_ff @(posedge clk_i) begin
    if (ctl.en[4]) begin
      s5_x_q    <= s4_x_q;
      s5_neg_q  <= s4_neg_q;
      s5_prod_q <= 33'(alpha_q) * 33'(s4_d_q);
    end
  end

  // stage 6: round, clamp, negate
  logic [16:0] mag6_raw, mag6;
  logic [15:0] y6;
  logic [15:0] s6_y_q;

  always_comb begin
    mag6_raw = 17'((34'(s5_prod_q) + 34'h80000) >> 20);
    mag6     = (mag6_raw > 17'd32768) ? 17'd32768 : mag6_raw;
    y6       = s5_neg_q ? 16'(OneQ16 - mag6) : s5_x_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[5]) begin
      s6_y_q <= y6;
    end
  end

  assign y_chan_o.valid = ctl.vld[NumStages-1];
  assign y_chan_o.y_out = s6_y_q;

endmodule

`default_nettype wire

// File: src/elu_activation_chk.sv
`default_nettype none

`include "elu_activation_top_defines.svh"

module elu_activation_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic signed [15:0] y_out_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  `ELU_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result item dropped while stalled")

  `ELU_ASSERT_NOW(a_ready_flow, out_ready_i, in_ready_i, "input stalled while output drains")

  `ELU_ASSERT_NOW(a_neg_range, out_valid_i, (y_out_i >= -16'sd4096), "negative result below -16.0")

  `ELU_ASSERT_NEXT(a_latency, (in_acc && out_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i, "item not delivered after six free cycles")

endmodule

bind elu_activation_top elu_activation_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (x_chan_i.valid),
  .in_ready_i  (x_chan_i.ready),
  .out_valid_i (y_chan_o.valid),
  .out_ready_i (y_chan_o.ready),
  .y_out_i     (y_chan_o.y_out)
);

`default_nettype wire
